### src/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the bounded deque and its storage cells.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int ValW = 32;

  localparam logic [2:0] CmdPushFront = 3'd0;
  localparam logic [2:0] CmdPushRear  = 3'd1;
  localparam logic [2:0] CmdPopFront  = 3'd2;
  localparam logic [2:0] CmdPopRear   = 3'd3;
  localparam logic [2:0] CmdRemove    = 3'd4;
  localparam logic [2:0] CmdReadOut   = 3'd5;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef struct packed {
    logic [2:0]             cmd;
    logic signed [ValW-1:0] value;
  } bdq_in_t;

  typedef struct packed {
    logic [1:0]             status;
    logic signed [ValW-1:0] data;
    logic                   last;
    logic [4:0]             count;
  } bdq_out_t;

  typedef enum logic [2:0] {
    OpNone,
    OpPushFront,
    OpPushRear,
    OpPopFront,
    OpRemove,
    OpRotate
  } bdq_op_e;

  typedef struct packed {
    bdq_op_e                op;
    logic signed [ValW-1:0] key;
  } bdq_ctrl_t;

endpackage

### src/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage slot of the deque; shifts with its neighbors and compares
// its entry against the search key.
// ----------------------------------------------------------------------------
module bdq_cell #(
  parameter int CntW = 5,
  parameter int Idx  = 0
) (
  input  logic                            clk_i,
  input  bdq_pkg::bdq_ctrl_t              ctrl_i,
  input  logic [CntW-1:0]                 count_i,
  input  logic signed [bdq_pkg::ValW-1:0] head_i,
  input  logic signed [bdq_pkg::ValW-1:0] left_val_i,
  input  logic signed [bdq_pkg::ValW-1:0] right_val_i,
  input  logic                            found_i,
  input  logic signed [bdq_pkg::ValW-1:0] tail_i,
  output logic signed [bdq_pkg::ValW-1:0] val_o,
  output logic                            found_o,
  output logic signed [bdq_pkg::ValW-1:0] tail_o
);
  import bdq_pkg::*;

  logic signed [ValW-1:0] val_q, val_d;
  logic                   valid, is_last, is_tail, match;

  assign valid   = count_i > CntW'(Idx);
  assign is_last = count_i == CntW'(Idx + 1);
  assign is_tail = count_i == CntW'(Idx);
  assign match   = valid && (val_q == ctrl_i.key);
  assign found_o = found_i | match;
  assign tail_o  = is_last ? val_q : tail_i;
  assign val_o   = val_q;

  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      OpPushFront: val_d = left_val_i;
      OpPushRear:  if (is_tail) val_d = ctrl_i.key;
      OpPopFront:  val_d = right_val_i;
      OpRemove:    if (found_o) val_d = right_val_i;
      OpRotate: begin
        if (is_last) val_d = head_i;
        else if (valid) val_d = right_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

### src/bounded_deque_search_delete.sv
// ----------------------------------------------------------------------------
// bounded_deque_search_delete
// Bounded double-ended queue of signed values with remove-by-value.
// ----------------------------------------------------------------------------
// Input channel: one command beat (push front/rear, pop front/rear, remove
// value, read out). Output channel: result beats with status, data, last
// and the entry count after the command.
// Entries sit in a row of cells, front at cell 0. Every update (push, pop,
// remove with per-cell compare and shift) completes in the accept cycle, and
// the single result beat appears in the cycle after acceptance. A command is
// taken every cycle while no read out is busy and the output register is free
// or being drained. Read out emits one beat per entry, one per cycle unless
// the receiver stalls, by rotating the row one cell per beat, and holds off
// commands until its last beat is issued. Unused command codes are taken and
// give no beat. Reset empties the queue at once. When the receiver stalls, the
// result holds in the output register and the next command waits for it.
// ----------------------------------------------------------------------------
module bounded_deque_search_delete #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdq_pkg::bdq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bdq_pkg::bdq_out_t out_data_o
);
  import bdq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]        count_q, count_d, rd_left_q, rd_left_d;
  logic                   rd_busy_q, rd_busy_d;
  logic                   out_valid_q, out_valid_d;
  bdq_out_t               out_q, out_d;
  bdq_ctrl_t              ctrl;
  logic                   out_free, acc;

  logic signed [ValW-1:0] cell_val   [DEPTH];
  logic                   cell_found [DEPTH];
  logic signed [ValW-1:0] cell_tail  [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bdq_cell #(.CntW(CntW), .Idx(g)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .head_i     (cell_val[0]),
      .left_val_i ((g == 0) ? ctrl.key : cell_val[(g == 0) ? 0 : g - 1]),
      .right_val_i(cell_val[(g == DEPTH - 1) ? g : g + 1]),
      .found_i    ((g == 0) ? 1'b0 : cell_found[(g == 0) ? 0 : g - 1]),
      .tail_i     ((g == 0) ? '0 : cell_tail[(g == 0) ? 0 : g - 1]),
      .val_o      (cell_val[g]),
      .found_o    (cell_found[g]),
      .tail_o     (cell_tail[g])
    );
  end

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !rd_busy_q && out_free;
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    ctrl        = '{op: OpNone, key: in_data_i.value};
    count_d     = count_q;
    rd_left_d   = rd_left_q;
    rd_busy_d   = rd_busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (acc) begin
      out_d = '{status: StOk, data: '0, last: 1'b1, count: 5'(count_q)};
      unique case (in_data_i.cmd)
        CmdPushFront, CmdPushRear: begin
          out_valid_d = 1'b1;
          if (count_q == CntW'(DEPTH)) begin
            out_d.status = StFull;
          end else begin
            ctrl.op     = (in_data_i.cmd == CmdPushFront) ? OpPushFront : OpPushRear;
            count_d     = count_q + 1'b1;
            out_d.count = 5'(count_d);
          end
        end
        CmdPopFront, CmdPopRear: begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_d.status = StEmpty;
          end else begin
            ctrl.op     = (in_data_i.cmd == CmdPopFront) ? OpPopFront : OpNone;
            out_d.data  = (in_data_i.cmd == CmdPopFront) ? cell_val[0]
                                                         : cell_tail[DEPTH-1];
            count_d     = count_q - 1'b1;
            out_d.count = 5'(count_d);
          end
        end
        CmdRemove: begin
          out_valid_d = 1'b1;
          ctrl.op     = OpRemove;
          if (cell_found[DEPTH-1]) begin
            out_d.data  = in_data_i.value;
            count_d     = count_q - 1'b1;
            out_d.count = 5'(count_d);
          end else begin
            out_d.status = StNotFound;
          end
        end
        CmdReadOut: begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_d.status = StEmpty;
          end else begin
            ctrl.op    = OpRotate;
            out_d.data = cell_val[0];
            out_d.last = count_q == CntW'(1);
            rd_left_d  = count_q - 1'b1;
            rd_busy_d  = count_q != CntW'(1);
          end
        end
        default: out_valid_d = out_valid_q && !out_ready_i;
      endcase
    end else if (rd_busy_q && out_free) begin
      ctrl.op     = OpRotate;
      out_valid_d = 1'b1;
      out_d       = '{status: StOk, data: cell_val[0], last: rd_left_q == CntW'(1),
                      count: 5'(count_q)};
      rd_left_d   = rd_left_q - 1'b1;
      rd_busy_d   = rd_left_q != CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_left_q   <= '0;
      rd_busy_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_left_q   <= rd_left_d;
      rd_busy_q   <= rd_busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count exceeds depth");

  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_busy_q |-> !in_ready_o)
    else $error("command taken during read out");

  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.cmd == CmdPushFront || in_data_i.cmd == CmdPushRear) &&
    count_q == CntW'(DEPTH) |=> out_valid_q && out_q.status == StFull &&
    count_q == CntW'(DEPTH))
    else $error("push into full queue not refused");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_data_i.cmd == CmdPopFront || in_data_i.cmd == CmdPopRear) &&
    count_q != '0 |=> count_q == CntW'($past(count_q) - 1'b1))
    else $error("pop did not drop one entry");

  a_busy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_busy_q |-> rd_left_q != '0)
    else $error("read out busy with no beats left");

endmodule

### tb/tb_bounded_deque_search_delete.sv
// ----------------------------------------------------------------------------
// tb_bounded_deque_search_delete
// Self-checking bench for the bounded deque with remove-by-value.
// ----------------------------------------------------------------------------
// Commands go in as single beats over a valid/ready channel with random gaps.
// A mirror of the deque contents works out the result beats each accepted
// command must give. Every result beat is compared field by field against
// the oldest one due. A directed opening covers the empty and full cases,
// extreme values, duplicate removal and the unused command codes. Random
// phases follow with push-heavy, pop-heavy and remove-heavy mixes, one long
// receiver hold-off that backs the block up, and pauses until all results
// are in. The final phase adds no random gaps or receiver stalls.
// ----------------------------------------------------------------------------
module tb_bounded_deque_search_delete;
  timeunit 1ns;
  timeprecision 1ps;

  import bdq_pkg::*;

  localparam int Depth = 16;
  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;

  class deque_mirror;
    logic signed [ValW-1:0] cells[$];
    bdq_out_t beats_due[$];
    int errors = 0;

    function void add_due(logic [1:0] st, logic signed [ValW-1:0] d, logic lst);
      bdq_out_t b;
      b.status = st;
      b.data = d;
      b.last = lst;
      b.count = 5'(cells.size());
      beats_due.push_back(b);
    endfunction

    function void take_command(bdq_in_t c);
      int hit;
      logic signed [ValW-1:0] d;
      hit = -1;
      case (c.cmd) inside
        CmdPushFront, CmdPushRear: begin
          if (cells.size() >= Depth) begin
            add_due(StFull, '0, 1'b1);
          end else begin
            if (c.cmd == CmdPushFront) begin
              cells.push_front(c.value);
            end else begin
              cells.push_back(c.value);
            end
            add_due(StOk, '0, 1'b1);
          end
        end
        CmdPopFront, CmdPopRear: begin
          if (cells.size() == 0) begin
            add_due(StEmpty, '0, 1'b1);
          end else begin
            if (c.cmd == CmdPopFront) begin
              d = cells.pop_front();
            end else begin
              d = cells.pop_back();
            end
            add_due(StOk, d, 1'b1);
          end
        end
        CmdRemove: begin
          foreach (cells[i]) begin
            if (hit < 0 && cells[i] == c.value) hit = i;
          end
          if (hit < 0) begin
            add_due(StNotFound, '0, 1'b1);
          end else begin
            d = cells[hit];
            cells.delete(hit);
            add_due(StOk, d, 1'b1);
          end
        end
        CmdReadOut: begin
          if (cells.size() == 0) begin
            add_due(StEmpty, '0, 1'b1);
          end else begin
            foreach (cells[i]) begin
              add_due(StOk, cells[i], i == cells.size() - 1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_beat(bdq_out_t got);
      bdq_out_t want;
      if (beats_due.size() == 0) begin
        $error("result beat with nothing due: status %0d data %0d", got.status, got.data);
        errors++;
        return;
      end
      want = beats_due.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.data !== want.data) begin
        $error("data: expected %0d, got %0d", want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  bdq_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  bdq_out_t out_data_o;

  deque_mirror mirror = new;
  bit calm;
  bit sink_hold_req;
  int sink_stall;

  bounded_deque_search_delete #(
    .DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    out_ready_i = 1'b0;
    sink_stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) mirror.check_beat(out_data_o);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_stall = 80;
      end else if (sink_stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        sink_stall = $urandom_range(1, 14);
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic offer_command(input logic [2:0] cmd, input logic signed [ValW-1:0] val);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{cmd: cmd, value: val};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    mirror.take_command(in_data_i);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (mirror.beats_due.size() != 0);
  endtask

  function automatic logic signed [ValW-1:0] pick_value(input bit from_held);
    int k;
    k = $urandom_range(0, 9);
    if (from_held && mirror.cells.size() != 0 && k < 6) begin
      return mirror.cells[$urandom_range(0, mirror.cells.size() - 1)];
    end
    if (k < 4) begin
      return int'($urandom_range(0, 6)) - 3;
    end
    if (k == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom();
  endfunction

  task automatic run_mix(input int beats, input int w_push, input int w_pop, input int w_rem,
                         input int w_read, input int w_spare);
    int r;
    logic [2:0] cmd;
    for (int n = 0; n < beats; n++) begin
      r = $urandom_range(0, w_push + w_pop + w_rem + w_read + w_spare - 1);
      if (r < w_push) begin
        cmd = $urandom_range(0, 1) ? CmdPushRear : CmdPushFront;
      end else if (r < w_push + w_pop) begin
        cmd = $urandom_range(0, 1) ? CmdPopRear : CmdPopFront;
      end else if (r < w_push + w_pop + w_rem) begin
        cmd = CmdRemove;
      end else if (r < w_push + w_pop + w_rem + w_read) begin
        cmd = CmdReadOut;
      end else begin
        cmd = $urandom_range(0, 1) ? CmdSpareB : CmdSpareA;
      end
      offer_command(cmd, pick_value(cmd == CmdRemove));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_command(CmdReadOut, '0);
    offer_command(CmdPopFront, '0);
    offer_command(CmdPopRear, '0);
    offer_command(CmdRemove, 32'sd5);
    offer_command(CmdPushFront, 32'h7fff_ffff);
    offer_command(CmdPushRear, 32'h8000_0000);
    offer_command(CmdPushFront, -32'sd1);
    for (int n = 0; n < Depth - 3; n++) begin
      offer_command(n[0] ? CmdPushRear : CmdPushFront, 32'(n % 3));
    end
    offer_command(CmdPushFront, 32'sd9);
    offer_command(CmdPushRear, 32'sd9);
    offer_command(CmdRemove, 32'sd1);
    offer_command(CmdRemove, 32'sd77);
    offer_command(CmdReadOut, '0);
    offer_command(CmdPopFront, '0);
    offer_command(CmdPopRear, '0);
    offer_command(CmdSpareA, 32'sd3);
    offer_command(CmdSpareB, -32'sd1);

    run_mix(30, 4, 3, 2, 1, 1);
    drain_wait();
    sink_hold_req = 1'b1;
    run_mix(40, 8, 1, 1, 1, 0);
    run_mix(60, 3, 2, 5, 1, 1);
    drain_wait();
    run_mix(25, 1, 6, 2, 1, 0);
    run_mix(25, 6, 1, 1, 2, 0);
    drain_wait();
    calm = 1'b1;
    run_mix(50, 4, 3, 2, 1, 1);
    drain_wait();
    repeat (20) @(posedge clk_i);

    if (mirror.beats_due.size() != 0) begin
      $error("%0d result beats never arrived", mirror.beats_due.size());
      mirror.errors++;
    end
    if (mirror.errors == 0) begin
      $display("tb_bounded_deque_search_delete: clean");
    end else begin
      $display("tb_bounded_deque_search_delete: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_bounded_deque_search_delete: errors");
    $finish;
  end

endmodule
